FILE: rtl/dtq_pkg.sv
// shared types and codes for the delta timer queue
`default_nettype none
package dtq_pkg;
   localparam logic [2:0] KIND_ALLOC  = 3'd0;
   localparam logic [2:0] KIND_ADD    = 3'd1;
   localparam logic [2:0] KIND_REMOVE = 3'd2;
   localparam logic [2:0] KIND_DELETE = 3'd3;
   localparam logic [2:0] KIND_TICK   = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_FREE   = 2'd1;
   localparam logic [1:0] ST_NOT_QUEUED = 2'd2;
   localparam logic [1:0] ST_BAD_HANDLE = 2'd3;

   localparam int MAX_FIRE = 16;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_DECODE = 10'b0000000010,
      S_UWALK  = 10'b0000000100,
      S_UFIX   = 10'b0000001000,
      S_IRD    = 10'b0000010000,
      S_IWALK  = 10'b0000100000,
      S_IFIN   = 10'b0001000000,
      S_TCHK   = 10'b0010000000,
      S_TDEC   = 10'b0100000000,
      S_OUT    = 10'b1000000000
   } state_type;
endpackage
`default_nettype wire

FILE: rtl/delta_timer_queue.sv
// delta timer queue: sorted delta list of timer nodes under a walking sequencer
// allocate, bad handle and undefined kinds answer without a list walk; remove and delete
// unlink a queued node (one link per unlink cycle); add unlinks a queued node, then inserts
// tick: unlinks zero-delta head nodes, then decrements the head delta; one item in flight
// last beat waits in an output register, so the next item can be accepted meanwhile
// reset clears link, flag and head state at once; delta memory is not cleared
`default_nettype none
module delta_timer_queue
   import dtq_pkg::*;
#(
   parameter int NODES = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [2:0]  req_kind,
   input  wire  [5:0]  req_handle,
   input  wire  [31:0] req_delay,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_node_id,
   output logic        rsp_fired,
   output logic        rsp_done_res,
   output logic        rsp_last
);
   localparam int IW = $clog2(NODES);
   localparam int CW = $clog2(NODES + 1);

   state_type state_ff, state_in;
   logic [31:0] mem [NODES];
   logic [31:0] rd_ff;
   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [31:0]   wr_data;

   logic [IW-1:0] nxt_ff [NODES], nxt_in [NODES];
   logic [NODES-1:0] nnull_ff, nnull_in;
   logic [NODES-1:0] use_ff, use_in, que_ff, que_in, cmp_ff, cmp_in;
   logic [IW-1:0] head_ff, head_in;
   logic          hnull_ff, hnull_in;

   logic [2:0]    kind_ff, kind_in;
   logic [IW-1:0] node_ff, node_in;
   logic [IW-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic          cnull_ff, cnull_in, pnull_ff, pnull_in;
   logic [31:0]   t_ff, t_in, dn_ff, dn_in;
   logic [CW-1:0] steps_ff, steps_in;
   logic [4:0]    fires_ff, fires_in;
   logic          pend_ff, pend_in; // fired beat held until the next head check
   logic          after_ff, after_in; // 0 unlink then done, 1 unlink then insert
   logic          phase_ff, phase_in; // unlink: waiting for node delta read

   logic          ov_ff, ov_in;
   logic [1:0]    ost_ff, ost_in;
   logic [5:0]    oid_ff, oid_in;
   logic          ofr_ff, ofr_in, odn_ff, odn_in, olast_ff, olast_in;
   logic [1:0]    rst_ff, rst_in;
   logic [5:0]    rid_ff, rid_in;
   logic          rfr_ff, rfr_in, rdn_ff, rdn_in, rlast_ff, rlast_in;
   logic [1:0]    ret_ff, ret_in; // 0 idle, 1 tick continue

   logic [IW-1:0] free_idx;
   logic          free_any;
   logic          hvalid;

   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      for (int i = NODES - 1; i >= 0; i--) begin
         if (!use_ff[i]) begin
            free_idx = IW'(i);
            free_any = 1'b1;
         end
      end
   end

   assign hvalid = ({26'd0, req_handle} < 32'(NODES));
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_status = rst_ff;
   assign rsp_node_id = rid_ff;
   assign rsp_fired = rfr_ff;
   assign rsp_done_res = rdn_ff;
   assign rsp_last = rlast_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      nxt_in = nxt_ff; nnull_in = nnull_ff;
      use_in = use_ff; que_in = que_ff; cmp_in = cmp_ff;
      head_in = head_ff; hnull_in = hnull_ff;
      kind_in = kind_ff; node_in = node_ff;
      cur_in = cur_ff; prev_in = prev_ff; cnull_in = cnull_ff; pnull_in = pnull_ff;
      t_in = t_ff; dn_in = dn_ff; steps_in = steps_ff; fires_in = fires_ff;
      pend_in = pend_ff;
      after_in = after_ff; phase_in = phase_ff;
      ov_in = ov_ff; ost_in = ost_ff; oid_in = oid_ff; ofr_in = ofr_ff;
      odn_in = odn_ff; olast_in = olast_ff; ret_in = ret_ff;
      rst_in = rst_ff; rid_in = rid_ff; rfr_in = rfr_ff; rdn_in = rdn_ff;
      rlast_in = rlast_ff;
      rd_addr = cur_ff; wr_en = 1'b0; wr_addr = cur_ff; wr_data = '0;
      if (ov_ff && rsp_ready) ov_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               kind_in = req_kind;
               node_in = req_handle[IW-1:0];
               ost_in = ST_OK; oid_in = '0; ofr_in = 1'b0; odn_in = 1'b0;
               olast_in = 1'b1; ret_in = 2'd0;
               state_in = S_OUT;
               if (req_kind == KIND_ALLOC) begin
                  if (free_any) begin
                     use_in[free_idx] = 1'b1; que_in[free_idx] = 1'b0;
                     cmp_in[free_idx] = 1'b0; nnull_in[free_idx] = 1'b1;
                     wr_en = 1'b1; wr_addr = free_idx; wr_data = req_delay;
                     oid_in = 6'(free_idx);
                  end else begin
                     ost_in = ST_NO_FREE;
                  end
               end else if (req_kind == KIND_ADD || req_kind == KIND_REMOVE
                            || req_kind == KIND_DELETE) begin
                  oid_in = req_handle;
                  if (!hvalid || !use_ff[req_handle[IW-1:0]]) begin
                     ost_in = ST_BAD_HANDLE;
                  end else begin
                     state_in = S_DECODE;
                  end
               end else if (req_kind == KIND_TICK) begin
                  fires_in = '0;
                  pend_in = 1'b0;
                  phase_in = 1'b0;
                  olast_in = 1'b0;
                  cur_in = head_ff;
                  state_in = S_TCHK;
               end
            end
         end
         S_DECODE: begin
            // start an unlink walk from the head, or skip it when the node is not queued
            cur_in = head_ff; cnull_in = hnull_ff; pnull_in = 1'b1;
            steps_in = '0; phase_in = 1'b0;
            after_in = (kind_ff == KIND_ADD);
            if (kind_ff == KIND_REMOVE && !que_ff[node_ff]) begin
               ost_in = ST_NOT_QUEUED; odn_in = cmp_ff[node_ff];
               state_in = S_OUT;
            end else if (!que_ff[node_ff]) begin
               state_in = (kind_ff == KIND_ADD) ? S_IRD : S_IFIN;
               rd_addr = node_ff;
            end else begin
               state_in = S_UWALK;
            end
         end
         S_UWALK: begin
            // walk to node; then read its delta
            if (!cnull_ff && cur_ff != node_ff && steps_ff < CW'(NODES)) begin
               prev_in = cur_ff; pnull_in = 1'b0;
               cur_in = nxt_ff[cur_ff]; cnull_in = nnull_ff[cur_ff];
               steps_in = steps_ff + 1'b1;
            end else if (cnull_ff || cur_ff != node_ff) begin
               state_in = S_IFIN;
               rd_addr = node_ff;
            end else begin
               rd_addr = node_ff;
               state_in = S_UFIX;
               phase_in = 1'b0;
            end
         end
         S_UFIX: begin
            if (!phase_ff) begin
               dn_in = rd_ff;
               rd_addr = nxt_ff[node_ff];
               phase_in = 1'b1;
            end else begin
               if (!nnull_ff[node_ff]) begin
                  wr_en = 1'b1; wr_addr = nxt_ff[node_ff]; wr_data = rd_ff + dn_ff;
               end
               if (pnull_ff) begin
                  head_in = nxt_ff[node_ff]; hnull_in = nnull_ff[node_ff];
               end else begin
                  nxt_in[prev_ff] = nxt_ff[node_ff]; nnull_in[prev_ff] = nnull_ff[node_ff];
               end
               nnull_in[node_ff] = 1'b1; que_in[node_ff] = 1'b0;
               rd_addr = node_ff;
               phase_in = 1'b0;
               if (kind_ff == KIND_TICK) state_in = S_TCHK;
               else if (after_ff) state_in = S_IRD;
               else state_in = S_IFIN;
               cur_in = hnull_in ? head_ff : head_in;
            end
         end
         S_IRD: begin
            // node delta valid in rd_ff now (address held at node)
            rd_addr = head_ff;
            t_in = rd_ff;
            cur_in = head_ff; cnull_in = hnull_ff; pnull_in = 1'b1;
            steps_in = '0; phase_in = 1'b0;
            state_in = S_IWALK;
         end
         S_IWALK: begin
            rd_addr = cur_ff;
            if (!phase_ff && !cnull_ff && steps_ff < CW'(NODES)) begin
               phase_in = 1'b1; // wait for the registered read data
            end else if (cnull_ff || steps_ff >= CW'(NODES)) begin
               wr_en = 1'b1; wr_addr = node_ff; wr_data = t_ff;
               nxt_in[node_ff] = cur_ff; nnull_in[node_ff] = 1'b1;
               if (pnull_ff) begin head_in = node_ff; hnull_in = 1'b0; end
               else begin nxt_in[prev_ff] = node_ff; nnull_in[prev_ff] = 1'b0; end
               que_in[node_ff] = 1'b1;
               state_in = S_IFIN;
            end else if (t_ff <= rd_ff) begin
               wr_en = 1'b1; wr_addr = cur_ff; wr_data = rd_ff - t_ff;
               nxt_in[node_ff] = cur_ff; nnull_in[node_ff] = 1'b0;
               if (pnull_ff) begin head_in = node_ff; hnull_in = 1'b0; end
               else begin nxt_in[prev_ff] = node_ff; nnull_in[prev_ff] = 1'b0; end
               que_in[node_ff] = 1'b1;
               state_in = S_IRD; phase_in = 1'b0;
               // delta of node written next cycle
               t_in = t_ff; after_in = 1'b0; kind_in = kind_ff;
               state_in = S_IFIN;
               cur_in = node_ff; cnull_in = 1'b1; // flag: pending node write
            end else begin
               t_in = t_ff - rd_ff;
               prev_in = cur_ff; pnull_in = 1'b0;
               cur_in = nxt_ff[cur_ff]; cnull_in = nnull_ff[cur_ff];
               steps_in = steps_ff + 1'b1; phase_in = 1'b0;
               rd_addr = nxt_ff[cur_ff];
            end
         end
         S_IFIN: begin
            if (kind_ff == KIND_ADD) begin
               wr_en = 1'b1; wr_addr = node_ff; wr_data = t_ff;
               odn_in = cmp_ff[node_ff];
            end else if (kind_ff == KIND_REMOVE) begin
               odn_in = cmp_ff[node_ff];
            end else begin
               use_in[node_ff] = 1'b0; que_in[node_ff] = 1'b0;
               cmp_in[node_ff] = 1'b0; nnull_in[node_ff] = 1'b1;
            end
            state_in = S_OUT;
         end
         S_TCHK: begin
            rd_addr = head_ff;
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (!hnull_ff && rd_ff == 32'd0 && fires_ff < 5'(MAX_FIRE)) begin
                  if (pend_ff) begin
                     // another node fires: the held beat is not the last one
                     pend_in = 1'b0; ret_in = 2'd1;
                     state_in = S_OUT;
                  end else begin
                     node_in = head_ff; cmp_in[head_ff] = 1'b1;
                     ost_in = ST_OK; oid_in = 6'(head_ff); ofr_in = 1'b1; odn_in = 1'b1;
                     olast_in = 1'b0;
                     fires_in = fires_ff + 1'b1;
                     pend_in = 1'b1;
                     cur_in = head_ff; cnull_in = 1'b0; pnull_in = 1'b1;
                     rd_addr = head_ff;
                     state_in = S_UFIX;
                  end
               end else begin
                  state_in = S_TDEC;
               end
            end
         end
         S_TDEC: begin
            if (!hnull_ff && rd_ff != 32'd0) begin
               wr_en = 1'b1; wr_addr = head_ff; wr_data = rd_ff - 32'd1;
            end
            if (fires_ff == '0) begin
               ost_in = ST_OK; oid_in = '0; ofr_in = 1'b0; odn_in = 1'b0;
            end
            olast_in = 1'b1;
            pend_in = 1'b0;
            ret_in = 2'd0;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!ov_ff) begin
               ov_in = 1'b1;
               rst_in = ost_ff; rid_in = oid_ff; rfr_in = ofr_ff; rdn_in = odn_ff;
               rlast_in = olast_ff;
               state_in = (ret_ff == 2'd1) ? S_TCHK : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < NODES; i++) nxt_ff[i] <= '0;
         nnull_ff <= '1; use_ff <= '0; que_ff <= '0; cmp_ff <= '0;
         head_ff <= '0; hnull_ff <= 1'b1; ov_ff <= 1'b0; ret_ff <= 2'd0;
         phase_ff <= 1'b0; fires_ff <= '0; pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         nxt_ff <= nxt_in; nnull_ff <= nnull_in;
         use_ff <= use_in; que_ff <= que_in; cmp_ff <= cmp_in;
         head_ff <= head_in; hnull_ff <= hnull_in; ov_ff <= ov_in; ret_ff <= ret_in;
         phase_ff <= phase_in; fires_ff <= fires_in; pend_ff <= pend_in;
      end
      kind_ff <= kind_in; node_ff <= node_in; cur_ff <= cur_in; prev_ff <= prev_in;
      cnull_ff <= cnull_in; pnull_ff <= pnull_in; t_ff <= t_in; dn_ff <= dn_in;
      steps_ff <= steps_in; after_ff <= after_in;
      ost_ff <= ost_in; oid_ff <= oid_in; ofr_ff <= ofr_in; odn_ff <= odn_in;
      olast_ff <= olast_in;
      rst_ff <= rst_in; rid_ff <= rid_in; rfr_ff <= rfr_in; rdn_ff <= rdn_in;
      rlast_ff <= rlast_in;
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == S_IDLE)) else $error("ready outside idle");
   a_queued_used: assert property (@(posedge clock) disable iff (reset)
      (que_ff & ~use_ff) == '0) else $error("queued node not in use");
   a_fired_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fired) |-> rsp_done_res) else $error("fired without done");
endmodule
`default_nettype wire

FILE: tb/sv/tb_delta_timer_queue.sv
// testbench for delta_timer_queue: random and directed commands checked against a delta-list predictor
`timescale 1ns / 100ps
module tb_delta_timer_queue
   import dtq_pkg::*;
();

   localparam int POOL = 16;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] node_id;
      logic       fired;
      logic       done_res;
      logic       last;
   } timer_rsp_type;

   class timer_scoreboard;
      bit [31:0] delta [POOL];
      int        link [POOL];
      bit        used [POOL];
      bit        linked [POOL];
      bit        expired [POOL];
      int        head;
      timer_rsp_type pending_rsp [$];
      int        errors;

      function new();
         for (int i = 0; i < POOL; i++) begin
            delta[i] = '0;
            link[i] = -1;
            used[i] = 0;
            linked[i] = 0;
            expired[i] = 0;
         end
         head = -1;
         errors = 0;
      endfunction

      function void push_rsp(logic [1:0] st, int id, bit fr, bit dn, bit lst);
         timer_rsp_type r;
         r.status = st;
         r.node_id = id[5:0];
         r.fired = fr;
         r.done_res = dn;
         r.last = lst;
         pending_rsp.push_back(r);
      endfunction

      function void unlink_timer(int n);
         int prev, cur, steps, succ;
         prev = -1;
         cur = head;
         steps = 0;
         while (cur >= 0 && cur != n && steps < POOL) begin
            prev = cur;
            cur = link[cur];
            steps++;
         end
         if (cur != n) return;
         succ = link[n];
         if (succ >= 0) delta[succ] += delta[n];
         if (prev < 0) head = succ;
         else link[prev] = succ;
         link[n] = -1;
         linked[n] = 0;
      endfunction

      function void insert_timer(int n);
         bit [31:0] t;
         int prev, cur, steps;
         t = delta[n];
         prev = -1;
         cur = head;
         steps = 0;
         while (cur >= 0 && steps < POOL) begin
            if (t <= delta[cur]) begin
               delta[cur] -= t;
               break;
            end
            t -= delta[cur];
            prev = cur;
            cur = link[cur];
            steps++;
         end
         link[n] = cur;
         delta[n] = t;
         if (prev < 0) head = n;
         else link[prev] = n;
         linked[n] = 1;
      endfunction

      // one accepted command beat
      function void note_command(logic [2:0] kind, logic [5:0] handle, logic [31:0] delay);
         int h, k, n;
         bit found;
         h = handle;
         if (kind == KIND_ALLOC) begin
            found = 0;
            for (int i = 0; i < POOL && !found; i++) begin
               if (!used[i]) begin
                  used[i] = 1;
                  delta[i] = delay;
                  link[i] = -1;
                  linked[i] = 0;
                  expired[i] = 0;
                  push_rsp(ST_OK, i, 0, 0, 1);
                  found = 1;
               end
            end
            if (!found) push_rsp(ST_NO_FREE, 0, 0, 0, 1);
         end else if (kind == KIND_ADD || kind == KIND_REMOVE || kind == KIND_DELETE) begin
            if (h >= POOL || !used[h]) begin
               push_rsp(ST_BAD_HANDLE, h, 0, 0, 1);
            end else if (kind == KIND_ADD) begin
               if (linked[h]) unlink_timer(h);
               insert_timer(h);
               push_rsp(ST_OK, h, 0, expired[h], 1);
            end else if (kind == KIND_REMOVE) begin
               if (!linked[h]) begin
                  push_rsp(ST_NOT_QUEUED, h, 0, expired[h], 1);
               end else begin
                  unlink_timer(h);
                  push_rsp(ST_OK, h, 0, expired[h], 1);
               end
            end else begin
               if (linked[h]) unlink_timer(h);
               used[h] = 0;
               linked[h] = 0;
               expired[h] = 0;
               link[h] = -1;
               push_rsp(ST_OK, h, 0, 0, 1);
            end
         end else if (kind == KIND_TICK) begin
            k = 0;
            while (k < MAX_FIRE && head >= 0 && delta[head] == 0) begin
               n = head;
               expired[n] = 1;
               unlink_timer(n);
               push_rsp(ST_OK, n, 1, 1, 0);
               k++;
            end
            if (head >= 0 && delta[head] != 0) delta[head] -= 1;
            if (k == 0) push_rsp(ST_OK, 0, 0, 0, 1);
            else pending_rsp[pending_rsp.size() - 1].last = 1;
         end else begin
            push_rsp(ST_OK, 0, 0, 0, 1);
         end
      endfunction

      function void check_rsp(timer_rsp_type got);
         timer_rsp_type want;
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat %p", $time, got);
            return;
         end
         want = pending_rsp.pop_front();
         if (want != got) begin
            errors++;
            $display("%0t: result mismatch expected %p actual %p", $time, want, got);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_kind = '0;
   logic [5:0]  req_handle = '0;
   logic [31:0] req_delay = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [5:0]  rsp_node_id;
   logic        rsp_fired;
   logic        rsp_done_res;
   logic        rsp_last;

   timer_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_off = 0;
   int cycles = 0;

   delta_timer_queue dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_handle(req_handle), .req_delay(req_delay),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_node_id(rsp_node_id), .rsp_fired(rsp_fired),
      .rsp_done_res(rsp_done_res), .rsp_last(rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_command(req_kind, req_handle, req_delay);
   end

   always @(posedge clock) begin
      timer_rsp_type r;
      if (!reset && rsp_valid && rsp_ready) begin
         r.status = rsp_status;
         r.node_id = rsp_node_id;
         r.fired = rsp_fired;
         r.done_res = rsp_done_res;
         r.last = rsp_last;
         sb.check_rsp(r);
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // valid goes low only on a gap, so one nonblocking write per edge
   task automatic send_cmd(logic [2:0] kind, logic [5:0] handle, logic [31:0] delay);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_handle <= handle;
      req_delay <= delay;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [31:0] pick_delay();
      case ($urandom_range(9))
         6, 7: return $urandom_range(40);
         8: return $urandom;
         9: return 32'hFFFF_FFFF;
         default: return $urandom_range(4);
      endcase
   endfunction

   function automatic logic [5:0] pick_handle();
      if ($urandom_range(9) < 8) return 6'($urandom_range(POOL - 1));
      return 6'($urandom_range(63));
   endfunction

   task automatic random_cmds(int count);
      int w;
      for (int i = 0; i < count; i++) begin
         w = $urandom_range(99);
         if (w < 20) send_cmd(KIND_ALLOC, 6'($urandom_range(63)), pick_delay());
         else if (w < 48) send_cmd(KIND_ADD, pick_handle(), $urandom);
         else if (w < 58) send_cmd(KIND_REMOVE, pick_handle(), $urandom);
         else if (w < 67) send_cmd(KIND_DELETE, pick_handle(), $urandom);
         else if (w < 96) send_cmd(KIND_TICK, 6'($urandom_range(63)), $urandom);
         else send_cmd(3'($urandom_range(7, 5)), 6'($urandom_range(63)), $urandom);
      end
   endtask

   // fill the pool with short timers, queue them all, tick them out and delete them
   task automatic burst_cmds();
      for (int i = 0; i <= POOL; i++) send_cmd(KIND_ALLOC, 6'd0, $urandom_range(1));
      for (int i = 0; i < POOL; i++) send_cmd(KIND_ADD, 6'(i), 32'd0);
      for (int i = 0; i < 3; i++) send_cmd(KIND_TICK, 6'd0, 32'd0);
      for (int i = 0; i < POOL; i++) send_cmd(KIND_DELETE, 6'(i), 32'd0);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      send_cmd(KIND_TICK, 6'd0, 32'd0);
      send_cmd(KIND_REMOVE, 6'd63, 32'd0);
      send_cmd(KIND_ADD, 6'd0, 32'd0);
      send_cmd(KIND_ALLOC, 6'd0, 32'hFFFF_FFFF);
      send_cmd(KIND_ALLOC, 6'd0, 32'd0);
      send_cmd(KIND_ALLOC, 6'd0, 32'd3);
      send_cmd(KIND_ADD, 6'd0, 32'd0);
      send_cmd(KIND_ADD, 6'd1, 32'd0);
      send_cmd(KIND_ADD, 6'd2, 32'd0);
      send_cmd(KIND_ADD, 6'd2, 32'd0);
      send_cmd(KIND_REMOVE, 6'd2, 32'd0);
      send_cmd(KIND_REMOVE, 6'd2, 32'd0);
      send_cmd(KIND_TICK, 6'd0, 32'd0);
      send_cmd(KIND_ADD, 6'd1, 32'd0);
      send_cmd(3'd5, 6'd63, 32'hFFFF_FFFF);
      send_cmd(3'd6, 6'd0, 32'd0);
      send_cmd(3'd7, 6'd0, 32'd0);
      send_cmd(KIND_DELETE, 6'd0, 32'd0);
      send_cmd(KIND_DELETE, 6'd1, 32'd0);
      send_cmd(KIND_DELETE, 6'd20, 32'd0);
      send_cmd(KIND_DELETE, 6'd2, 32'd0);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 47 : (ph == 3) ? 16 : 0;
         recv_stall_pct = (ph == 2) ? 47 : (ph == 3) ? 16 : 0;
         burst_cmds();
         random_cmds(40);
      end

      // long receiver hold-off while commands keep coming
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off = 1;
      fork
         random_cmds(30);
         begin
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
      join
      random_cmds(20);

      req_valid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule

FILE: files.f
rtl/dtq_pkg.sv
rtl/delta_timer_queue.sv
tb/sv/tb_delta_timer_queue.sv
